// File: hw/rtl/fjsp_pkg.sv
package fjsp_pkg;

  // Parser phases, one-hot.
  typedef enum logic [10:0] {
    PH_SEEK      = 11'b000_0000_0001,
    PH_BETWEEN   = 11'b000_0000_0010,
    PH_KEY       = 11'b000_0000_0100,
    PH_KEY_ESC   = 11'b000_0000_1000,
    PH_KEY_HEX   = 11'b000_0001_0000,
    PH_AFTER_KEY = 11'b000_0010_0000,
    PH_PRE_VAL   = 11'b000_0100_0000,
    PH_VAL       = 11'b000_1000_0000,
    PH_VAL_ESC   = 11'b001_0000_0000,
    PH_VAL_HEX   = 11'b010_0000_0000,
    PH_DONE      = 11'b100_0000_0000
  } phase_e;

  // Result kinds as seen on the output word.
  typedef enum logic [1:0] {
    KIND_KEY      = 2'd0,
    KIND_VALUE    = 2'd1,
    KIND_PAIR_END = 2'd2,
    KIND_DOC_END  = 2'd3
  } kind_e;

  // One result word, without its run_last flag.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       kept;
    logic       ok;
  } entry_t;

  // All result words caused by one input byte.
  typedef struct packed {
    logic [2:0]   count;
    entry_t [3:0] ent;
  } bundle_t;

  // Characters the parser looks for.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  // UTF-8 encoding limits and prefixes.
  localparam logic [15:0] Utf1Max  = 16'h007F;
  localparam logic [15:0] Utf2Max  = 16'h07FF;
  localparam logic [7:0]  UtfLead2 = 8'hC0;
  localparam logic [7:0]  UtfLead3 = 8'hE0;
  localparam logic [7:0]  UtfCont  = 8'h80;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
  endfunction

  // Returns {valid, digit value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/fjsp_core.sv
module fjsp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  input  logic              end_of_text_i,
  output fjsp_pkg::bundle_t bundle_o
);
  import fjsp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [11:0] acc_q, acc_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic        key_seen_q, key_seen_d;
  logic        val_seen_q, val_seen_d;

  logic [1:0]  str_n;
  logic [7:0]  str_b [3];
  logic        str_val;
  logic        pair_end, pair_kept;
  logic        doc_end, doc_ok;
  logic        active;
  logic [4:0]  hex;
  logic [15:0] cp;
  logic [2:0]  n_pre;

  // Next state and the result words for the byte on the input.
  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    hcnt_d     = hcnt_q;
    key_seen_d = key_seen_q;
    val_seen_d = val_seen_q;
    str_n      = 2'd0;
    str_b[0]   = 8'd0;
    str_b[1]   = 8'd0;
    str_b[2]   = 8'd0;
    str_val    = 1'b0;
    pair_end   = 1'b0;
    pair_kept  = 1'b0;
    doc_end    = 1'b0;
    doc_ok     = 1'b0;
    active     = 1'b1;
    hex        = hex_digit(in_byte_i);
    cp         = {acc_q, hex[3:0]};

    unique case (phase_q)
      PH_DONE: begin
        active = 1'b0;
        if (end_of_text_i) begin
          phase_d = PH_SEEK;
        end
      end
      PH_SEEK: begin
        if (in_byte_i == CH_LBRACE) begin
          phase_d = PH_BETWEEN;
        end
      end
      PH_BETWEEN: begin
        if (is_ws(in_byte_i) || in_byte_i == CH_COMMA) begin
          phase_d = PH_BETWEEN;
        end else if (in_byte_i == CH_RBRACE) begin
          doc_end = 1'b1;
          doc_ok  = 1'b1;
        end else if (in_byte_i == CH_QUOTE) begin
          phase_d    = PH_KEY;
          key_seen_d = 1'b0;
          val_seen_d = 1'b0;
        end else begin
          doc_end = 1'b1;
        end
      end
      PH_KEY, PH_VAL: begin
        str_val = (phase_q == PH_VAL);
        if (in_byte_i == CH_QUOTE) begin
          if (str_val) begin
            pair_end  = 1'b1;
            pair_kept = key_seen_q && val_seen_q;
            phase_d   = PH_BETWEEN;
          end else begin
            phase_d = PH_AFTER_KEY;
          end
        end else if (in_byte_i == CH_BSLASH) begin
          phase_d = str_val ? PH_VAL_ESC : PH_KEY_ESC;
        end else begin
          str_n    = 2'd1;
          str_b[0] = in_byte_i;
        end
      end
      PH_KEY_ESC, PH_VAL_ESC: begin
        str_val = (phase_q == PH_VAL_ESC);
        if (in_byte_i == CH_LOW_U) begin
          phase_d = str_val ? PH_VAL_HEX : PH_KEY_HEX;
          hcnt_d  = 2'd0;
          acc_d   = 12'd0;
        end else begin
          str_n    = 2'd1;
          str_b[0] = unescape(in_byte_i);
          phase_d  = str_val ? PH_VAL : PH_KEY;
        end
      end
      PH_KEY_HEX, PH_VAL_HEX: begin
        str_val = (phase_q == PH_VAL_HEX);
        if (!hex[4]) begin
          doc_end = 1'b1;
        end else if (hcnt_q == 2'd3) begin
          // Fourth digit: encode the code point as UTF-8.
          if (cp <= Utf1Max) begin
            str_n    = 2'd1;
            str_b[0] = cp[7:0];
          end else if (cp <= Utf2Max) begin
            str_n    = 2'd2;
            str_b[0] = UtfLead2 | {3'd0, cp[10:6]};
            str_b[1] = UtfCont | {2'd0, cp[5:0]};
          end else begin
            str_n    = 2'd3;
            str_b[0] = UtfLead3 | {4'd0, cp[15:12]};
            str_b[1] = UtfCont | {2'd0, cp[11:6]};
            str_b[2] = UtfCont | {2'd0, cp[5:0]};
          end
          acc_d   = 12'd0;
          hcnt_d  = 2'd0;
          phase_d = str_val ? PH_VAL : PH_KEY;
        end else begin
          acc_d  = cp[11:0];
          hcnt_d = hcnt_q + 2'd1;
        end
      end
      PH_AFTER_KEY: begin
        if (in_byte_i == CH_COLON) begin
          phase_d = PH_PRE_VAL;
        end else if (!is_ws(in_byte_i)) begin
          doc_end = 1'b1;
        end
      end
      PH_PRE_VAL: begin
        if (in_byte_i == CH_QUOTE) begin
          phase_d = PH_VAL;
        end else if (!is_ws(in_byte_i)) begin
          doc_end = 1'b1;
        end
      end
      default: begin
        phase_d = PH_SEEK;
        if (in_byte_i == CH_LBRACE) begin
          phase_d = PH_BETWEEN;
        end
      end
    endcase

    // Any emitted string byte marks its string as non-empty.
    if (str_n != 2'd0) begin
      if (str_val) begin
        val_seen_d = 1'b1;
      end else begin
        key_seen_d = 1'b1;
      end
    end

    // End of text closes the document; it succeeds only between pairs.
    if (active && !doc_end && end_of_text_i) begin
      doc_end = 1'b1;
      doc_ok  = (phase_d == PH_BETWEEN);
    end

    if (doc_end) begin
      phase_d    = end_of_text_i ? PH_SEEK : PH_DONE;
      acc_d      = 12'd0;
      hcnt_d     = 2'd0;
      key_seen_d = 1'b0;
      val_seen_d = 1'b0;
    end
  end

  // Pack string bytes, then the pair end, then the document end.
  always_comb begin
    n_pre = {1'b0, str_n} + {2'd0, pair_end};
    bundle_o.count = n_pre + {2'd0, doc_end};
    for (int i = 0; i < 4; i++) begin
      bundle_o.ent[i] = '{kind: KIND_KEY, data: 8'd0, kept: 1'b0, ok: 1'b0};
      if (3'(i) < {1'b0, str_n}) begin
        bundle_o.ent[i].kind = str_val ? KIND_VALUE : KIND_KEY;
        bundle_o.ent[i].data = str_b[i % 3];
      end else if (pair_end && i == 0) begin
        bundle_o.ent[i].kind = KIND_PAIR_END;
        bundle_o.ent[i].kept = pair_kept;
      end else if (doc_end && 3'(i) == n_pre) begin
        bundle_o.ent[i].kind = KIND_DOC_END;
        bundle_o.ent[i].ok   = doc_ok;
      end
    end
  end

  // Parser state advances on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SEEK;
      acc_q      <= 12'd0;
      hcnt_q     <= 2'd0;
      key_seen_q <= 1'b0;
      val_seen_q <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      acc_q      <= acc_d;
      hcnt_q     <= hcnt_d;
      key_seen_q <= key_seen_d;
      val_seen_q <= val_seen_d;
    end
  end

endmodule

// File: hw/rtl/fjsp_serializer.sv
module fjsp_serializer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  fjsp_pkg::bundle_t bundle_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output fjsp_pkg::entry_t  entry_o,
  output logic              run_last_o,
  output logic              can_load_o
);
  import fjsp_pkg::*;

  entry_t [3:0] ent_q;
  logic [2:0]   count_q, count_d;
  logic [1:0]   pos_q, pos_d;
  logic         last;
  logic         taken;

  assign out_valid_o = (count_q != 3'd0);
  assign last        = (({1'b0, pos_q} + 3'd1) == count_q);
  assign taken       = out_valid_o && !out_stall_i;
  assign entry_o     = ent_q[pos_q];
  assign run_last_o  = last;
  // The buffer takes a new bundle when empty or when its last word leaves now.
  assign can_load_o  = !out_valid_o || (last && taken);

  // Step through the held words, one per output handshake.
  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    if (taken) begin
      if (last) begin
        count_d = 3'd0;
        pos_d   = 2'd0;
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end
    if (load_i) begin
      count_d = bundle_i.count;
      pos_d   = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
      pos_q   <= 2'd0;
    end else begin
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  // Result words carry no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= bundle_i.ent;
    end
  end

endmodule

// File: hw/rtl/flat_json_string_pair_parser.sv
// Channel  Direction  Handshake             Word
// input    in         in_valid_i/in_stall_o  in_byte_i, end_of_text_i
// output   out        out_valid_o/out_stall_i kind_o, out_byte_o, pair_kept_o,
//                                            doc_ok_o, run_last_o
//
// One byte is accepted per cycle when in_stall_o is low; its results appear
// the next cycle. A byte yields k words (k is 0 to 4), which the output
// buffer hands out one per cycle unless stalled; a \u escape yields up to 4.
// Reset puts the parser in the seek-for-brace phase with an empty buffer.
// in_stall_o is high while the buffer holds words that do not all leave this
// cycle; a stall on the output backs up into the input this way.
module flat_json_string_pair_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       pair_kept_o,
  output logic       doc_ok_o,
  output logic       run_last_o
);
  import fjsp_pkg::*;

  bundle_t bundle;
  entry_t  entry;
  logic    accept;
  logic    can_load;

  assign in_stall_o = !can_load;
  assign accept     = in_valid_i && can_load;

  // Parser state and per-byte decode.
  fjsp_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .bundle_o      (bundle)
  );

  // Result buffer that hands out one word per cycle unless the output stalls.
  fjsp_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && (bundle.count != 3'd0)),
    .bundle_i    (bundle),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .entry_o     (entry),
    .run_last_o  (run_last_o),
    .can_load_o  (can_load)
  );

  assign kind_o      = entry.kind;
  assign out_byte_o  = entry.data;
  assign pair_kept_o = entry.kept;
  assign doc_ok_o    = entry.ok;

endmodule

// File: hw/rtl/fjsp_checker.sv
module fjsp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       end_of_text_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [7:0] out_byte_o,
  input logic       pair_kept_o,
  input logic       doc_ok_o,
  input logic       run_last_o
);
  import fjsp_pkg::*;

  // A stalled output word holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(out_byte_o) && $stable(pair_kept_o) && $stable(doc_ok_o) &&
      $stable(run_last_o))
    else $error("output word changed while stalled");

  // With nothing buffered the input is never stalled.
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // The document end is always the final word of its byte.
  a_doc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DOC_END |-> run_last_o && out_byte_o == 8'd0)
    else $error("document end not last or carries a byte");

  // A run that is not finished continues in the next cycle.
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o)
    else $error("result run broken off");

  // A pair end carries neither byte nor document status.
  a_pair_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_PAIR_END |-> out_byte_o == 8'd0 && !doc_ok_o)
    else $error("pair end carries stray fields");

endmodule

bind flat_json_string_pair_parser fjsp_checker u_fjsp_checker (.*);

// File: tb/flat_json_string_pair_parser_tb.sv
module flat_json_string_pair_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fjsp_pkg::*;

  // One expected output word, run_last included.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       kept;
    logic       ok;
    logic       last;
  } word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] out_byte_o;
  logic       pair_kept_o;
  logic       doc_ok_o;
  logic       run_last_o;

  // Parser state as predicted by the testbench.
  phase_e      ph = PH_SEEK;
  logic [15:0] acc = '0;
  logic [1:0]  nhex = '0;
  logic        key_any = 1'b0;
  logic        val_any = 1'b0;

  word_t      expected_words[$];
  word_t      step_words[$];
  logic [7:0] doc_q[$];
  int         errors = 0;
  int         parsed_bytes = 0;
  int         hold_left = 0;
  bit         calm = 1'b0;

  flat_json_string_pair_parser dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .end_of_text_i(end_of_text_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .pair_kept_o  (pair_kept_o),
    .doc_ok_o     (doc_ok_o),
    .run_last_o   (run_last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic is_blank(input logic [7:0] b);
    return b == " " || b == "\t" || b == "\n" || b == 8'h0D;
  endfunction

  // Returns {is hex digit, digit value}.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    if (b >= "0" && b <= "9") begin
      return {1'b1, b[3:0]};
    end
    if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
      return {1'b1, b[3:0] + 4'd9};
    end
    return 5'd0;
  endfunction

  function automatic logic [7:0] escape_byte(input logic [7:0] b);
    case (b)
      "b":     return 8'h08;
      "f":     return 8'h0C;
      "n":     return 8'h0A;
      "r":     return 8'h0D;
      "t":     return 8'h09;
      default: return b;
    endcase
  endfunction

  // Appends one byte to the document being built.
  task automatic put_byte(input logic [7:0] b);
    doc_q.insert(doc_q.size(), b);
  endtask

  task automatic add_word(input kind_e k, input logic [7:0] d, input logic kept,
                          input logic ok);
    word_t w;
    w = '{kind: k, data: d, kept: kept, ok: ok, last: 1'b0};
    step_words.insert(step_words.size(), w);
  endtask

  // A decoded string byte also marks its string as non-empty.
  task automatic add_text(input logic in_val, input logic [7:0] d);
    if (in_val) begin
      val_any = 1'b1;
      add_word(KIND_VALUE, d, 1'b0, 1'b0);
    end else begin
      key_any = 1'b1;
      add_word(KIND_KEY, d, 1'b0, 1'b0);
    end
  endtask

  // Advances the predicted parser by one accepted byte and queues its words.
  task automatic parse_byte(input logic [7:0] b, input logic eot);
    logic        stop;
    logic        good;
    logic        in_val;
    logic [4:0]  dig;
    logic [15:0] cp;
    word_t       w;
    step_words.delete();
    stop = 1'b0;
    good = 1'b0;
    if (ph == PH_DONE) begin
      // Trailing bytes after a finished document are dropped up to the end mark.
      if (eot) ph = PH_SEEK;
    end else begin
      parsed_bytes++;
      case (ph)
        PH_SEEK: begin
          if (b == CH_LBRACE) ph = PH_BETWEEN;
        end
        PH_BETWEEN: begin
          if (is_blank(b) || b == CH_COMMA) begin
          end else if (b == CH_RBRACE) begin
            stop = 1'b1;
            good = 1'b1;
          end else if (b == CH_QUOTE) begin
            ph = PH_KEY;
            key_any = 1'b0;
            val_any = 1'b0;
          end else begin
            stop = 1'b1;
          end
        end
        PH_KEY, PH_VAL: begin
          in_val = (ph == PH_VAL);
          if (b == CH_QUOTE) begin
            if (in_val) begin
              add_word(KIND_PAIR_END, 8'h00, key_any & val_any, 1'b0);
              ph = PH_BETWEEN;
            end else begin
              ph = PH_AFTER_KEY;
            end
          end else if (b == CH_BSLASH) begin
            ph = in_val ? PH_VAL_ESC : PH_KEY_ESC;
          end else begin
            add_text(in_val, b);
          end
        end
        PH_KEY_ESC, PH_VAL_ESC: begin
          in_val = (ph == PH_VAL_ESC);
          if (b == CH_LOW_U) begin
            ph = in_val ? PH_VAL_HEX : PH_KEY_HEX;
            nhex = '0;
            acc = '0;
          end else begin
            add_text(in_val, escape_byte(b));
            ph = in_val ? PH_VAL : PH_KEY;
          end
        end
        PH_KEY_HEX, PH_VAL_HEX: begin
          in_val = (ph == PH_VAL_HEX);
          dig = hex_value(b);
          if (!dig[4]) begin
            stop = 1'b1;
          end else begin
            cp = {acc[11:0], dig[3:0]};
            if (nhex == 2'd3) begin
              // Fourth digit: emit the code point as UTF-8.
              if (cp <= Utf1Max) begin
                add_text(in_val, cp[7:0]);
              end else if (cp <= Utf2Max) begin
                add_text(in_val, UtfLead2 | cp[13:6]);
                add_text(in_val, UtfCont | {2'b00, cp[5:0]});
              end else begin
                add_text(in_val, UtfLead3 | {4'h0, cp[15:12]});
                add_text(in_val, UtfCont | {2'b00, cp[11:6]});
                add_text(in_val, UtfCont | {2'b00, cp[5:0]});
              end
              acc = '0;
              nhex = '0;
              ph = in_val ? PH_VAL : PH_KEY;
            end else begin
              acc = cp;
              nhex = nhex + 2'd1;
            end
          end
        end
        PH_AFTER_KEY: begin
          if (b == CH_COLON) ph = PH_PRE_VAL;
          else if (!is_blank(b)) stop = 1'b1;
        end
        PH_PRE_VAL: begin
          if (b == CH_QUOTE) ph = PH_VAL;
          else if (!is_blank(b)) stop = 1'b1;
        end
        default: begin
          ph = (b == CH_LBRACE) ? PH_BETWEEN : PH_SEEK;
        end
      endcase

      // End of text succeeds only between pairs.
      if (!stop && eot) begin
        stop = 1'b1;
        good = (ph == PH_BETWEEN);
      end
      if (stop) begin
        add_word(KIND_DOC_END, 8'h00, 1'b0, good);
        ph = eot ? PH_SEEK : PH_DONE;
        acc = '0;
        nhex = '0;
        key_any = 1'b0;
        val_any = 1'b0;
      end
    end

    foreach (step_words[i]) begin
      w = step_words[i];
      w.last = (i == step_words.size() - 1);
      expected_words.insert(expected_words.size(), w);
    end
  endtask

  // Presents one byte after a random gap and waits until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_byte_i     <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o);
    parse_byte(b, eot);
  endtask

  task automatic send_text(input string s, input logic eot_on_last);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eot_on_last && (i == s.len() - 1));
    end
  endtask

  // Output side: random stall after each word, and the check of every word.
  always @(posedge clk_i) begin : collect
    word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: kind %0d, out_byte %0h", kind_o, out_byte_o);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (kind_o !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_o);
            errors++;
          end
          if (out_byte_o !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, out_byte_o);
            errors++;
          end
          if (pair_kept_o !== want.kept) begin
            $error("pair_kept: expected %0d, got %0d", want.kept, pair_kept_o);
            errors++;
          end
          if (doc_ok_o !== want.ok) begin
            $error("doc_ok: expected %0d, got %0d", want.ok, doc_ok_o);
            errors++;
          end
          if (run_last_o !== want.last) begin
            $error("run_last: expected %0d, got %0d", want.last, run_last_o);
            errors++;
          end
        end
        hold_left = calm ? 0 : $urandom_range(0, 5);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left > 0);
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + nib;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  task automatic add_blanks(input int maxn);
    logic [7:0] pick[4];
    pick = '{8'h20, 8'h09, 8'h0D, 8'h0A};
    repeat ($urandom_range(0, maxn)) put_byte(pick[2'($urandom_range(0, 3))]);
  endtask

  // A random string body of plain bytes, escapes and \u escapes.
  task automatic add_string_body();
    logic [7:0]  c;
    logic [15:0] cp;
    logic [7:0]  simple[8];
    simple = '{"b", "f", "n", "r", "t", CH_QUOTE, CH_BSLASH, "/"};
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
          put_byte(c);
        end
        6, 7: begin
          put_byte(CH_BSLASH);
          if ($urandom_range(0, 1)) begin
            c = simple[3'($urandom_range(0, 7))];
          end else begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_LOW_U);
          end
          put_byte(c);
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       cp = 16'($urandom_range(0, 16'h007F));
            1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
            default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
          endcase
          put_byte(CH_BSLASH);
          put_byte(CH_LOW_U);
          put_byte(hex_char(cp[15:12]));
          put_byte(hex_char(cp[11:8]));
          put_byte(hex_char(cp[7:4]));
          put_byte(hex_char(cp[3:0]));
        end
      endcase
    end
  endtask

  // Builds a mostly well-formed document, sometimes corrupted or cut short,
  // and sends it with the end mark on its last byte.
  task automatic send_random_doc();
    int npairs;
    int ending;
    int cut;
    doc_q.delete();
    repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
    put_byte(CH_LBRACE);
    npairs = $urandom_range(0, 3);
    for (int p = 0; p < npairs; p++) begin
      add_blanks(2);
      if (p > 0 && $urandom_range(0, 1)) put_byte(CH_COMMA);
      add_blanks(1);
      put_byte(CH_QUOTE);
      add_string_body();
      put_byte(CH_QUOTE);
      add_blanks(1);
      put_byte(CH_COLON);
      add_blanks(1);
      put_byte(CH_QUOTE);
      add_string_body();
      put_byte(CH_QUOTE);
    end
    ending = $urandom_range(0, 3);
    if (ending == 0) begin
      put_byte($urandom_range(0, 1) ? CH_COMMA : 8'h20);
    end else if (ending < 3) begin
      add_blanks(1);
      put_byte(CH_RBRACE);
      repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
    end
    // Occasional damage: one byte replaced, or the text cut short.
    if (doc_q.size() > 1 && $urandom_range(0, 5) == 0) begin
      doc_q[$urandom_range(1, doc_q.size() - 1)] = 8'($urandom_range(0, 255));
    end
    if (doc_q.size() > 1 && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, doc_q.size() - 1);
      doc_q = doc_q[0:cut - 1];
    end
    foreach (doc_q[i]) send_byte(doc_q[i], i == doc_q.size() - 1);
  endtask

  // Document boundaries: end before the brace, end on the brace, pairs,
  // whitespace kinds, empty strings, bad byte between pairs and ignored tail.
  task automatic test_framing();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_LBRACE, 1'b1);
    send_text(" {\"a\" :\t\"b\"},}", 1'b1);
    send_text("{\"\":\"\",\n", 1'b0);
    send_byte(8'h0D, 1'b0);
    send_text("\"k\":\"v\"x?", 1'b1);
  endtask

  // Every escape form in keys and values; end of text on the value's quote.
  task automatic test_escapes();
    send_text("{\"\\u00e9\\u20Ac\\t\":\"\\/\\q\\\"\\\\\\f\\n\\b\\r\\u0041\\uFFFF\"", 1'b1);
  endtask

  // Malformed and unterminated pairs.
  task automatic test_errors();
    send_text("{\"k\" \"v\"}", 1'b1);
    send_text("{\"k\":v", 1'b1);
    send_text("{\"\\u0G", 1'b1);
    send_text("{\"k", 1'b1);
    send_text("{\"k\":\"v\\u12", 1'b1);
  endtask

  // Random documents until the whole run has parsed about 300 bytes,
  // with some stretches free of idling on both sides.
  task automatic test_random_docs();
    while (parsed_bytes < 300) begin
      calm = ($urandom_range(0, 4) == 0);
      send_random_doc();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_framing();
    test_escapes();
    test_errors();
    test_random_docs();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
